### hdl/ecmprt_pkg.sv
package ecmprt_pkg;

  // table geometry
  localparam int DEST_ENTRIES = 1024;
  localparam int MAX_HOPS     = 4;

  // field widths
  localparam int DEST_W   = 10;
  localparam int COST_W   = 32;
  localparam int HOP_W    = 16;
  localparam int ACTION_W = 3;
  localparam int TOTAL_W  = 3;

  // derived widths
  localparam int SLOT_W  = $clog2(DEST_ENTRIES);
  localparam int CNT_W   = $clog2(MAX_HOPS + 1);
  localparam int IDX_W   = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
  localparam int HADDR_W = $clog2(DEST_ENTRIES * MAX_HOPS);

  // destination to slot: reciprocal multiply, then one compare and subtract
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP       = (1 << RECIP_SHIFT) / DEST_ENTRIES;
  localparam int PROD_W      = DEST_W + RECIP_SHIFT;
  localparam int QN_W        = DEST_W + $clog2(DEST_ENTRIES + 1);

  // stream packing
  localparam int IN_DEST_LSB   = 0;
  localparam int IN_COST_LSB   = IN_DEST_LSB + DEST_W;
  localparam int IN_HOP_LSB    = IN_COST_LSB + COST_W;
  localparam int IN_USED_W     = IN_HOP_LSB + HOP_W;
  localparam int IN_DATA_W     = ((IN_USED_W + 7) / 8) * 8;

  localparam int OUT_DEST_LSB  = 0;
  localparam int OUT_ACT_LSB   = OUT_DEST_LSB + DEST_W;
  localparam int OUT_COST_LSB  = OUT_ACT_LSB + ACTION_W;
  localparam int OUT_TOTAL_LSB = OUT_COST_LSB + COST_W;
  localparam int OUT_USED_W    = OUT_TOTAL_LSB + TOTAL_W;
  localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  // update outcome codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_NEW     = 3'd0,
    ACT_CHEAPER = 3'd1,
    ACT_ADDED   = 3'd2,
    ACT_DUP     = 3'd3,
    ACT_WORSE   = 3'd4,
    ACT_FULL    = 3'd5
  } action_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SLOT,
    ST_CHECK,
    ST_SCAN
  } state_t;

  // one destination record
  typedef struct packed {
    logic              valid;
    logic [COST_W-1:0] cost;
    logic [CNT_W-1:0]  count;
  } entry_t;

  // table access request from the sequencer
  typedef struct packed {
    logic               entry_we;
    logic [SLOT_W-1:0]  entry_waddr;
    entry_t             entry_wdata;
    logic               entry_re;
    logic [SLOT_W-1:0]  entry_raddr;
    logic               hop_we;
    logic [HADDR_W-1:0] hop_waddr;
    logic [HOP_W-1:0]   hop_wdata;
    logic               hop_re;
    logic [HADDR_W-1:0] hop_raddr;
  } tbl_req_t;

endpackage

### hdl/ecmp_route_table_update_core.sv
// channel  | direction | handshake        | tdata fields (lowest bit up)
// s        | in        | s_tvalid/tready  | dest_index 10, path_cost 32, next_hop 16, pad 6
// m        | out       | m_tvalid/tready  | dest_echo 10, action 3, best_cost 32, hop_total 3
//
// new, cheaper or worse path: states SLOT then CHECK, result registered as CHECK ends
// equal cost: SCAN then compares the n stored hops, one hop compare per cycle on the read port
// after reset a clearing pass over all DEST_ENTRIES records runs with s_tready low
// one request at a time; s_tready is high only while idle
// a result waits in the output register; the last step holds until it is taken
module ecmp_route_table_update_core import ecmprt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // dest_index, path_cost, next_hop, zero pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata   // dest_echo, action, best_cost, hop_total
);

  state_t              state, state_next;
  logic [SLOT_W-1:0]   clr_idx;
  logic [DEST_W-1:0]   dest_q;
  logic [COST_W-1:0]   cost_q;
  logic [HOP_W-1:0]    hop_q;
  logic [DEST_W-1:0]   quot;
  logic [SLOT_W-1:0]   slot, slot_next;
  logic [IDX_W-1:0]    scan_idx;

  logic [DEST_W-1:0]   out_dest;
  action_t             out_action;
  logic [COST_W-1:0]   out_cost;
  logic [TOTAL_W-1:0]  out_total;

  tbl_req_t            req;
  entry_t              ent;
  logic [HOP_W-1:0]    hop_rd;

  logic [DEST_W-1:0]   rem;
  logic [CNT_W-1:0]    cnt_lim;
  logic                cost_lt, cost_eq, hop_hit, scan_last, list_full;
  logic [HADDR_W-1:0]  hop_base;
  logic                out_free, out_load, fin, settle;
  action_t             res_action;
  logic [COST_W-1:0]   res_cost;
  logic [CNT_W-1:0]    res_count;
  logic                s_accept;

  ecmprt_tables u_tables (
    .clk      (clk),
    .req      (req),
    .entry_rd (ent),
    .hop_rd   (hop_rd)
  );

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // slot from quotient estimate, remainder below twice the table size
  always_comb begin
    rem = DEST_W'(QN_W'(dest_q) - QN_W'(quot) * QN_W'(DEST_ENTRIES));
    if (32'(rem) >= DEST_ENTRIES) begin
      slot_next = SLOT_W'(32'(rem) - DEST_ENTRIES);
    end else begin
      slot_next = SLOT_W'(rem);
    end
  end

  // compares on the stored record
  always_comb begin
    cnt_lim   = (ent.count > CNT_W'(MAX_HOPS)) ? CNT_W'(MAX_HOPS) : ent.count;
    cost_lt   = cost_q < ent.cost;
    cost_eq   = cost_q == ent.cost;
    hop_hit   = hop_rd == hop_q;
    scan_last = (CNT_W'(scan_idx) + CNT_W'(1)) == cnt_lim;
    list_full = ent.count >= CNT_W'(MAX_HOPS);
    hop_base  = HADDR_W'(slot) * HADDR_W'(MAX_HOPS);
  end

  // table requests and result selection
  always_comb begin
    req        = '0;
    fin        = 1'b0;
    settle     = 1'b0;
    res_action = ACT_WORSE;
    res_cost   = ent.cost;
    res_count  = ent.count;
    unique case (state)
      ST_CLEAR: begin
        req.entry_we    = 1'b1;
        req.entry_waddr = clr_idx;
      end
      ST_IDLE: begin
      end
      ST_SLOT: begin
        req.entry_re    = 1'b1;
        req.entry_raddr = slot_next;
      end
      ST_CHECK: begin
        if (!ent.valid || cost_lt) begin
          fin             = 1'b1;
          res_action      = ent.valid ? ACT_CHEAPER : ACT_NEW;
          res_cost        = cost_q;
          res_count       = CNT_W'(1);
          req.entry_we    = out_free;
          req.entry_waddr = slot;
          req.entry_wdata = '{valid: 1'b1, cost: cost_q, count: CNT_W'(1)};
          req.hop_we      = out_free;
          req.hop_waddr   = hop_base;
          req.hop_wdata   = hop_q;
        end else if (cost_eq) begin
          if (cnt_lim == '0) begin
            settle = 1'b1;
          end else begin
            req.hop_re    = 1'b1;
            req.hop_raddr = hop_base;
          end
        end else begin
          fin = 1'b1;
        end
      end
      ST_SCAN: begin
        if (hop_hit) begin
          fin        = 1'b1;
          res_action = ACT_DUP;
        end else if (scan_last) begin
          settle = 1'b1;
        end else begin
          req.hop_re    = 1'b1;
          req.hop_raddr = hop_base + HADDR_W'(scan_idx) + HADDR_W'(1);
        end
      end
      default: begin
      end
    endcase
    // equal cost with a new hop: append or report full
    if (settle) begin
      fin = 1'b1;
      if (list_full) begin
        res_action = ACT_FULL;
      end else begin
        res_action      = ACT_ADDED;
        res_count       = CNT_W'(ent.count + CNT_W'(1));
        req.entry_we    = out_free;
        req.entry_waddr = slot;
        req.entry_wdata = '{valid: 1'b1, cost: ent.cost, count: res_count};
        req.hop_we      = out_free;
        req.hop_waddr   = hop_base + HADDR_W'(ent.count);
        req.hop_wdata   = hop_q;
      end
    end
    out_load = fin && out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_idx == SLOT_W'(DEST_ENTRIES - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (s_tvalid) state_next = ST_SLOT;
      ST_SLOT:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end else if (req.hop_re) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + SLOT_W'(1);
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request capture and working registers
  always_ff @(posedge clk) begin
    if (s_accept) begin
      dest_q <= s_tdata[IN_DEST_LSB +: DEST_W];
      cost_q <= s_tdata[IN_COST_LSB +: COST_W];
      hop_q  <= s_tdata[IN_HOP_LSB +: HOP_W];
      quot   <= DEST_W'((PROD_W'(s_tdata[IN_DEST_LSB +: DEST_W]) * PROD_W'(RECIP))
                        >> RECIP_SHIFT);
    end
    if (state == ST_SLOT) begin
      slot <= slot_next;
    end
    if (req.hop_re) begin
      scan_idx <= (state == ST_CHECK) ? '0 : scan_idx + IDX_W'(1);
    end
    if (out_load) begin
      out_dest   <= dest_q;
      out_action <= res_action;
      out_cost   <= res_cost;
      out_total  <= TOTAL_W'(res_count);
    end
  end

  // result packing
  always_comb begin
    m_tdata = '0;
    m_tdata[OUT_DEST_LSB  +: DEST_W]   = out_dest;
    m_tdata[OUT_ACT_LSB   +: ACTION_W] = out_action;
    m_tdata[OUT_COST_LSB  +: COST_W]   = out_cost;
    m_tdata[OUT_TOTAL_LSB +: TOTAL_W]  = out_total;
  end

endmodule

### hdl/ecmprt_tables.sv
module ecmprt_tables import ecmprt_pkg::*; (
  input  logic             clk,
  input  tbl_req_t         req,
  output entry_t           entry_rd,
  output logic [HOP_W-1:0] hop_rd
);

  entry_t           entry_mem [DEST_ENTRIES];
  logic [HOP_W-1:0] hop_mem   [DEST_ENTRIES * MAX_HOPS];

  // destination records: one write, one registered read
  always_ff @(posedge clk) begin
    if (req.entry_we) begin
      entry_mem[req.entry_waddr] <= req.entry_wdata;
    end
    if (req.entry_re) begin
      entry_rd <= entry_mem[req.entry_raddr];
    end
  end

  // next-hop lists: one write, one registered read
  always_ff @(posedge clk) begin
    if (req.hop_we) begin
      hop_mem[req.hop_waddr] <= req.hop_wdata;
    end
    if (req.hop_re) begin
      hop_rd <= hop_mem[req.hop_raddr];
    end
  end

endmodule

### hdl/ecmprt_checker.sv
module ecmprt_checker import ecmprt_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // no request taken in the cycle after reset: clearing pass runs first
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("request port ready straight after reset");

  // one request at a time
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second request taken before the first finished");

  // a waiting result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

  // only defined outcome codes leave the block
  a_action_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (action_t'(m_tdata[OUT_ACT_LSB +: ACTION_W]) <= ACT_FULL))
    else $error("undefined outcome code");

endmodule

bind ecmp_route_table_update_core ecmprt_checker u_checker (.*);

### dv/tb_ecmp_route_table_update_core.sv
`timescale 1ns / 1ps

module tb_ecmp_route_table_update_core;
  import ecmprt_pkg::*;

  localparam int N_RANDOM       = 900;
  localparam int N_HOT          = 12;
  localparam int N_HOP_POOL     = 6;
  localparam int LONG_HOLD      = 200;
  localparam int HOLD_AT_REPORT = 300;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_SHOWN      = 10;

  // one route report, unpacked from m_tdata field by field
  typedef struct packed {
    logic [DEST_W-1:0]  dest;
    action_t            act;
    logic [COST_W-1:0]  cost;
    logic [TOTAL_W-1:0] total;
  } route_res_t;

  // directed request with an optional hand-written report
  typedef struct packed {
    logic [DEST_W-1:0]  dest;
    logic [COST_W-1:0]  cost;
    logic [HOP_W-1:0]   hop;
    logic               typed;
    action_t            act;
    logic [COST_W-1:0]  best;
    logic [TOTAL_W-1:0] total;
  } dir_row_t;

  localparam int N_DIRECTED = 19;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // dest_index, path_cost, next_hop, zero pad
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // dest_echo, action, best_cost, hop_total

  // shadow route table
  bit                 tbl_valid [DEST_ENTRIES];
  logic [COST_W-1:0]  tbl_cost  [DEST_ENTRIES];
  int                 tbl_count [DEST_ENTRIES];
  logic [HOP_W-1:0]   tbl_hops  [DEST_ENTRIES][MAX_HOPS];

  route_res_t pending_reports [$];

  int mismatches;
  int reports_taken;
  int quiet_cycles;
  int send_burst;
  int recv_burst;
  int act_seen [6];

  logic [DEST_W-1:0] hot_dests [N_HOT];
  logic [HOP_W-1:0]  hop_pool  [N_HOP_POOL];

  dir_row_t dir_rows [N_DIRECTED] = '{
    '{10'd0,    32'h0000_0000, 16'h0000, 1'b1, ACT_NEW,     32'h0000_0000, 3'd1},
    '{10'd1023, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, ACT_NEW,     32'hFFFF_FFFF, 3'd1},
    '{10'd1023, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, ACT_DUP,     32'hFFFF_FFFF, 3'd1},
    '{10'd1023, 32'hFFFF_FFFF, 16'h0000, 1'b1, ACT_ADDED,   32'hFFFF_FFFF, 3'd2},
    '{10'd1023, 32'hFFFF_FFFF, 16'h0001, 1'b1, ACT_ADDED,   32'hFFFF_FFFF, 3'd3},
    '{10'd1023, 32'hFFFF_FFFF, 16'hAAAA, 1'b1, ACT_ADDED,   32'hFFFF_FFFF, 3'd4},
    '{10'd1023, 32'hFFFF_FFFF, 16'h5555, 1'b1, ACT_FULL,    32'hFFFF_FFFF, 3'd4},
    '{10'd1023, 32'hFFFF_FFFF, 16'hAAAA, 1'b1, ACT_DUP,     32'hFFFF_FFFF, 3'd4},
    '{10'd1023, 32'hFFFF_FFFF, 16'h0000, 1'b1, ACT_DUP,     32'hFFFF_FFFF, 3'd4},
    '{10'd1023, 32'hFFFF_FFFE, 16'h1234, 1'b1, ACT_CHEAPER, 32'hFFFF_FFFE, 3'd1},
    '{10'd1023, 32'hFFFF_FFFF, 16'h0007, 1'b1, ACT_WORSE,   32'hFFFF_FFFE, 3'd1},
    '{10'd0,    32'h0000_0001, 16'h0009, 1'b1, ACT_WORSE,   32'h0000_0000, 3'd1},
    '{10'd0,    32'h0000_0000, 16'hFFFF, 1'b1, ACT_ADDED,   32'h0000_0000, 3'd2},
    '{10'd0,    32'h0000_0000, 16'h0000, 1'b1, ACT_DUP,     32'h0000_0000, 3'd2},
    '{10'h155,  32'h5555_5555, 16'h5555, 1'b0, ACT_NEW,     32'h0000_0000, 3'd0},
    '{10'h2AA,  32'hAAAA_AAAA, 16'hAAAA, 1'b0, ACT_NEW,     32'h0000_0000, 3'd0},
    '{10'h2AA,  32'h8000_0000, 16'h8000, 1'b1, ACT_CHEAPER, 32'h8000_0000, 3'd1},
    '{10'h155,  32'h5555_5555, 16'h5555, 1'b1, ACT_DUP,     32'h5555_5555, 3'd1},
    '{10'h155,  32'h5555_5554, 16'h5555, 1'b0, ACT_NEW,     32'h0000_0000, 3'd0}
  };

  ecmp_route_table_update_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // apply one offered path to the shadow table and return the report it gives
  function automatic route_res_t apply_route_update(input logic [DEST_W-1:0] dest,
      input logic [COST_W-1:0] cost, input logic [HOP_W-1:0] hop);
    route_res_t r;
    int         slot;
    bit         listed;
    slot   = dest % DEST_ENTRIES;
    listed = 1'b0;
    if (!tbl_valid[slot] || cost < tbl_cost[slot]) begin
      r.act = tbl_valid[slot] ? ACT_CHEAPER : ACT_NEW;
      tbl_valid[slot]   = 1'b1;
      tbl_cost[slot]    = cost;
      tbl_count[slot]   = 1;
      tbl_hops[slot][0] = hop;
    end else if (cost == tbl_cost[slot]) begin
      // every stored hop is searched, not only the first
      for (int i = 0; i < tbl_count[slot]; i++) begin
        if (tbl_hops[slot][i] == hop) listed = 1'b1;
      end
      if (listed) begin
        r.act = ACT_DUP;
      end else if (tbl_count[slot] >= MAX_HOPS) begin
        r.act = ACT_FULL;
      end else begin
        tbl_hops[slot][tbl_count[slot]] = hop;
        tbl_count[slot] = tbl_count[slot] + 1;
        r.act = ACT_ADDED;
      end
    end else begin
      r.act = ACT_WORSE;
    end
    r.dest  = dest;
    r.cost  = tbl_cost[slot];
    r.total = TOTAL_W'(tbl_count[slot]);
    return r;
  endfunction

  // idle cycles before the next request or report, with bursts of none
  function automatic int draw_gap(inout int burst);
    int gap;
    gap = 0;
    if (burst > 0) begin
      burst = burst - 1;
    end else if ($urandom_range(0, 15) == 0) begin
      burst = 20;
    end else begin
      gap = $urandom_range(0, 5);
    end
    return gap;
  endfunction

  // offer one request and hold it until the block takes it
  task automatic offer_update(input logic [DEST_W-1:0] dest, input logic [COST_W-1:0] cost,
      input logic [HOP_W-1:0] hop, input logic typed, input route_res_t typed_res);
    int                   gap;
    route_res_t           predicted;
    logic [IN_DATA_W-1:0] word;
    gap       = draw_gap(send_burst);
    predicted = apply_route_update(dest, cost, hop);
    pending_reports.insert(pending_reports.size(), typed ? typed_res : predicted);
    word = '0;
    word[IN_DEST_LSB +: DEST_W] = dest;
    word[IN_COST_LSB +: COST_W] = cost;
    word[IN_HOP_LSB  +: HOP_W]  = hop;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // report side: random stalls and one long hold to back the block up
  initial begin
    int stall;
    m_tready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (reports_taken == HOLD_AT_REPORT) stall = LONG_HOLD;
      else stall = draw_gap(recv_burst);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // compare each report with the oldest prediction
  always @(posedge clk) begin : check_reports
    route_res_t got;
    route_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.dest  = m_tdata[OUT_DEST_LSB  +: DEST_W];
      got.act   = action_t'(m_tdata[OUT_ACT_LSB +: ACTION_W]);
      got.cost  = m_tdata[OUT_COST_LSB  +: COST_W];
      got.total = m_tdata[OUT_TOTAL_LSB +: TOTAL_W];
      reports_taken = reports_taken + 1;
      if (got.act <= ACT_FULL) act_seen[got.act] = act_seen[got.act] + 1;
      if (pending_reports.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: report with nothing pending, dest %0d action %0d", $realtime,
                   got.dest, got.act);
      end else begin
        want = pending_reports.pop_front();
        if (got.dest !== want.dest || got.act !== want.act || got.cost !== want.cost ||
            got.total !== want.total) begin
          mismatches = mismatches + 1;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: mismatch exp/got dest %0d/%0d act %0d/%0d cost %h/%h hops %0d/%0d",
                     $realtime, want.dest, got.dest, want.act, got.act, want.cost, got.cost,
                     want.total, got.total);
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    route_res_t        row_res;
    logic [DEST_W-1:0] d;
    logic [COST_W-1:0] c;
    logic [HOP_W-1:0]  h;
    int                slot;
    mismatches    = 0;
    reports_taken = 0;
    quiet_cycles  = 0;
    send_burst    = 0;
    recv_burst    = 0;
    for (int k = 0; k < 6; k++) act_seen[k] = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table: extremes, every action, duplicate beyond the first hop
    for (int i = 0; i < N_DIRECTED; i++) begin
      row_res.dest  = dir_rows[i].dest;
      row_res.act   = dir_rows[i].act;
      row_res.cost  = dir_rows[i].best;
      row_res.total = dir_rows[i].total;
      offer_update(dir_rows[i].dest, dir_rows[i].cost, dir_rows[i].hop, dir_rows[i].typed,
                   row_res);
    end

    // random part: mostly a few busy destinations with costs near the stored one
    for (int k = 0; k < N_HOT; k++) hot_dests[k] = DEST_W'($urandom_range(0, 1023));
    for (int k = 0; k < N_HOP_POOL; k++) hop_pool[k] = HOP_W'($urandom_range(0, 65535));
    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 9) < 8) begin
        d    = hot_dests[$urandom_range(0, N_HOT - 1)];
        slot = d % DEST_ENTRIES;
        c    = tbl_valid[slot] ? tbl_cost[slot] : COST_W'($urandom);
        case ($urandom_range(0, 9)) inside
          6: c = c - COST_W'($urandom_range(1, 3));
          7: c = c + COST_W'($urandom_range(1, 3));
          [8:9]: c = $urandom;
          default: ;
        endcase
        if ($urandom_range(0, 19) < 17) h = hop_pool[$urandom_range(0, N_HOP_POOL - 1)];
        else h = HOP_W'($urandom_range(0, 65535));
      end else begin
        d = DEST_W'($urandom_range(0, 1023));
        c = $urandom;
        h = HOP_W'($urandom_range(0, 65535));
      end
      offer_update(d, c, h, 1'b0, row_res);
    end
    s_tvalid <= 1'b0;

    // drain
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d route updates checked, %0d mismatches", reports_taken, mismatches);
    $display("new %0d, cheaper %0d, added %0d, duplicate %0d, worse %0d, full %0d",
             act_seen[ACT_NEW], act_seen[ACT_CHEAPER], act_seen[ACT_ADDED],
             act_seen[ACT_DUP], act_seen[ACT_WORSE], act_seen[ACT_FULL]);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
